// ===== sv/rgb_pixel_blender_defines.svh =====
// assertion macros shared by the blender rtl
`ifndef RGB_PIXEL_BLENDER_DEFINES_SVH
`define RGB_PIXEL_BLENDER_DEFINES_SVH

// checked on every rising edge of clock, quiet while reset is high
`define RPB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising edge of clock, reset included
`define RPB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/rpb_pkg.sv =====
package rpb_pkg;

   localparam int CHAN_WIDTH   = 8;
   localparam int NUM_CHANNELS = 3;
   localparam int COLOR_WIDTH  = CHAN_WIDTH * NUM_CHANNELS;
   localparam int ALPHA_WIDTH  = 8;
   localparam int MODE_WIDTH   = 3;

   // code 7 is unused and blends to black like BLEND_BLACK
   typedef enum logic [MODE_WIDTH-1:0] {
      BLEND_BLACK    = 3'd0,
      BLEND_MIX      = 3'd1,
      BLEND_ADD      = 3'd2,
      BLEND_SUBTRACT = 3'd3,
      BLEND_MULTIPLY = 3'd4,
      BLEND_DODGE    = 3'd5,
      BLEND_INVERT   = 3'd6
   } blend_mode_type;

   // per-stage control handed from the top level to each channel
   typedef struct packed {
      logic           en;
      blend_mode_type mode_s0;
      blend_mode_type mode_s1;
      blend_mode_type mode_s2;
   } pipe_ctrl_type;

endpackage

// ===== sv/rpb_if.sv =====
interface rpb_req_if;
   logic                            valid;
   logic                            ready;
   logic [rpb_pkg::COLOR_WIDTH-1:0] base_color;
   logic [rpb_pkg::COLOR_WIDTH-1:0] new_color;
   logic [rpb_pkg::ALPHA_WIDTH-1:0] alpha;

   modport source (output valid, base_color, new_color, alpha, input ready);
   modport sink (input valid, base_color, new_color, alpha, output ready);
endinterface

interface rpb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rpb_pkg::COLOR_WIDTH-1:0] blended_color;

   modport source (output valid, blended_color, input ready);
   modport sink (input valid, blended_color, output ready);
endinterface

// ===== sv/rpb_channel.sv =====
module rpb_channel (
   input  logic                            clock,
   input  rpb_pkg::pipe_ctrl_type          ctrl,
   input  logic [rpb_pkg::CHAN_WIDTH-1:0]  base_chan,
   input  logic [rpb_pkg::CHAN_WIDTH-1:0]  new_chan,
   input  logic [rpb_pkg::ALPHA_WIDTH-1:0] alpha,
   output logic [rpb_pkg::CHAN_WIDTH-1:0]  result
);

   // stage 1: one shared signed multiplier, operands picked by mode
   logic signed [8:0]  mul_x;
   logic signed [8:0]  mul_y;
   logic signed [17:0] prod_in;
   logic signed [17:0] prod_ff;
   logic [7:0]         base1_ff;
   logic [7:0]         alpha1_ff;

   always_comb begin
      mul_x = 9'sd0;
      mul_y = 9'sd0;
      case (ctrl.mode_s0)
         rpb_pkg::BLEND_MIX: begin
            mul_x = $signed({1'b0, new_chan}) - $signed({1'b0, base_chan});
            mul_y = $signed({1'b0, alpha});
         end
         rpb_pkg::BLEND_ADD, rpb_pkg::BLEND_SUBTRACT: begin
            mul_x = $signed({1'b0, new_chan});
            mul_y = $signed({1'b0, alpha});
         end
         rpb_pkg::BLEND_MULTIPLY, rpb_pkg::BLEND_DODGE: begin
            mul_x = $signed({1'b0, new_chan});
            mul_y = $signed({1'b0, base_chan});
         end
         rpb_pkg::BLEND_INVERT: begin
            mul_x = $signed({1'b0, base_chan});
            mul_y = $signed({1'b0, alpha});
         end
         default: begin
            mul_x = 9'sd0;
            mul_y = 9'sd0;
         end
      endcase
      prod_in = mul_x * mul_y;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         prod_ff   <= prod_in;
         base1_ff  <= base_chan;
         alpha1_ff <= alpha;
      end
   end

   // stage 2: scale the product into the term added to or taken from base (multiply: the result itself)
   logic [23:0]       dodge_prod;
   logic signed [9:0] term_in;
   logic signed [9:0] term_ff;
   logic [7:0]        base2_ff;
   logic [7:0]        alpha2_ff;

   always_comb begin
      dodge_prod = 24'(prod_ff[15:0]) * 24'(alpha1_ff);
      case (ctrl.mode_s1)
         rpb_pkg::BLEND_MIX: term_in = prod_ff[17:8];   // floor shift
         rpb_pkg::BLEND_ADD, rpb_pkg::BLEND_SUBTRACT, rpb_pkg::BLEND_MULTIPLY:
            term_in = $signed({2'b00, prod_ff[15:8]});
         rpb_pkg::BLEND_DODGE: term_in = $signed({2'b00, dodge_prod[23:16]});
         rpb_pkg::BLEND_INVERT: term_in = $signed({1'b0, prod_ff[15:7]}); // 2ba >> 8
         default: term_in = 10'sd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         term_ff   <= term_in;
         base2_ff  <= base1_ff;
         alpha2_ff <= alpha1_ff;
      end
   end

   // stage 3: combine, clamp to 0..255, register the channel result
   logic signed [10:0] base_ext;
   logic signed [10:0] alpha_ext;
   logic signed [10:0] term_ext;
   logic signed [10:0] sum;
   logic [7:0]         result_in;
   logic [7:0]         result_ff;

   always_comb begin
      base_ext  = $signed({3'b000, base2_ff});
      alpha_ext = $signed({3'b000, alpha2_ff});
      term_ext  = $signed({term_ff[9], term_ff});
      case (ctrl.mode_s2)
         rpb_pkg::BLEND_MIX, rpb_pkg::BLEND_ADD, rpb_pkg::BLEND_DODGE:
            sum = base_ext + term_ext;
         rpb_pkg::BLEND_SUBTRACT: sum = base_ext - term_ext;
         rpb_pkg::BLEND_MULTIPLY: sum = term_ext;
         rpb_pkg::BLEND_INVERT:   sum = base_ext + alpha_ext - term_ext;
         default:                 sum = 11'sd0;
      endcase
      if (sum < 11'sd0) begin
         result_in = 8'd0;
      end else if (sum > 11'sd255) begin
         result_in = 8'd255;
      end else begin
         result_in = sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== sv/rgb_pixel_blender.sv =====
// channel   direction  role
// req_if    in         base_color, new_color, alpha per request
// rsp_if    out        blended_color, one per request
// csr_*     in         blend_mode write, no read-back
//
// three register stages: operand select + 9x9 multiply, scale (16x8 multiply
// for dodge), combine + clamp into the output register
// one request per cycle while the output is not held
// reset clears valid bits and blend_mode (black); payload is not reset
// when the output is held, the whole pipe freezes and nothing is lost

`include "rgb_pixel_blender_defines.svh"

module rgb_pixel_blender (
   input  logic                            clock,
   input  logic                            reset,
   rpb_req_if.sink                         req_if,
   rpb_rsp_if.source                       rsp_if,
   input  logic                            csr_wr_en,
   input  logic [rpb_pkg::MODE_WIDTH-1:0]  csr_wr_data
);

   // blend mode register
   rpb_pkg::blend_mode_type mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rpb_pkg::BLEND_BLACK;
      end else if (csr_wr_en) begin
         mode_ff <= rpb_pkg::blend_mode_type'(csr_wr_data);
      end
   end

   // pipe advances whenever the output slot is free or being drained
   logic advance;
   logic valid_s1_ff;
   logic valid_s2_ff;
   logic valid_s3_ff;
   rpb_pkg::blend_mode_type mode_s1_ff;
   rpb_pkg::blend_mode_type mode_s2_ff;

   assign advance      = !valid_s3_ff || rsp_if.ready;
   assign req_if.ready = advance;
   assign rsp_if.valid = valid_s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
         valid_s3_ff <= 1'b0;
      end else if (advance) begin
         valid_s1_ff <= req_if.valid;
         valid_s2_ff <= valid_s1_ff;
         valid_s3_ff <= valid_s2_ff;
      end
   end

   // mode travels with each request so every stage sees its own
   always_ff @(posedge clock) begin
      if (advance) begin
         mode_s1_ff <= mode_ff;
         mode_s2_ff <= mode_s1_ff;
      end
   end

   rpb_pkg::pipe_ctrl_type ctrl;

   always_comb begin
      ctrl.en      = advance;
      ctrl.mode_s0 = mode_ff;
      ctrl.mode_s1 = mode_s1_ff;
      ctrl.mode_s2 = mode_s2_ff;
   end

   // red, green and blue run through identical channel pipes
   for (genvar ch = 0; ch < rpb_pkg::NUM_CHANNELS; ch++) begin : g_chan
      rpb_channel u_chan (
         .clock     (clock),
         .ctrl      (ctrl),
         .base_chan (req_if.base_color[ch*rpb_pkg::CHAN_WIDTH +: rpb_pkg::CHAN_WIDTH]),
         .new_chan  (req_if.new_color[ch*rpb_pkg::CHAN_WIDTH +: rpb_pkg::CHAN_WIDTH]),
         .alpha     (req_if.alpha),
         .result    (rsp_if.blended_color[ch*rpb_pkg::CHAN_WIDTH +: rpb_pkg::CHAN_WIDTH])
      );
   end

   // no stale result right after reset
   `RPB_ASSERT_ALWAYS(a_reset_empties_output, reset |=> !rsp_if.valid, "output valid after reset")
   // an accepted request lands in stage 1
   `RPB_ASSERT(a_accept_enters_pipe, (req_if.valid && req_if.ready) |=> valid_s1_ff, "accepted request dropped")
   // a frozen pipe keeps its middle stage
   `RPB_ASSERT(a_stall_keeps_stage2, (valid_s2_ff && !advance) |=> valid_s2_ff, "request lost during stall")
   // black mode gives a black pixel
   `RPB_ASSERT(a_black_mode_zero, (valid_s2_ff && advance && (mode_s2_ff == rpb_pkg::BLEND_BLACK)) |=> (rsp_if.blended_color == '0), "black mode gave nonzero pixel")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   // selector code 7 is not in the package enum; the block turns it into black
   localparam logic [rpb_pkg::MODE_WIDTH-1:0] BLEND_UNUSED = 3'd7;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
   localparam int TAIL_CYCLES    = 16;    // idle cycles after the last response
   localparam int PHASE_PIXELS   = 50;    // random requests per blend mode setting
   localparam int NUM_PHASES     = 14;

   // one row of the directed table: a mode, a request and, where it is obvious,
   // the pixel that must come back
   typedef struct {
      logic [rpb_pkg::MODE_WIDTH-1:0]  mode;
      logic [rpb_pkg::COLOR_WIDTH-1:0] base_px;
      logic [rpb_pkg::COLOR_WIDTH-1:0] over_px;
      logic [rpb_pkg::ALPHA_WIDTH-1:0] alpha;
      bit                              known_v;
      logic [rpb_pkg::COLOR_WIDTH-1:0] known_px;
   } pixel_case_type;

   logic clock = 1'b0;
   logic reset;
   logic                           csr_wr_en;
   logic [rpb_pkg::MODE_WIDTH-1:0] csr_wr_data;

   rpb_req_if req_if ();
   rpb_rsp_if rsp_if ();

   rgb_pixel_blender i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // testbench copy of blend_mode, changed only while the pipe is empty
   logic [rpb_pkg::MODE_WIDTH-1:0] mode_shadow;

   // expectation that rides along with the request payload (directed rows)
   bit                              known_v;
   logic [rpb_pkg::COLOR_WIDTH-1:0] known_px;

   logic [rpb_pkg::COLOR_WIDTH-1:0] pending_pixels[$];  // blended colors still to come back
   pixel_case_type                  corner_cases[$];

   int sent_count     = 0;
   int result_count   = 0;
   int error_count    = 0;
   int idle_cycles    = 0;
   int mode_writes    = 0;
   int directed_count = 0;
   int burst_left     = 0;

   logic [rpb_pkg::COLOR_WIDTH-1:0] expected_px;

   // ---------------------------------------------------------------------
   // blend prediction
   // ---------------------------------------------------------------------

   // one 8-bit channel; b = base, n = new, a = alpha, worked in signed ints
   function automatic logic [rpb_pkg::CHAN_WIDTH-1:0] blend_chan(
         input logic [rpb_pkg::MODE_WIDTH-1:0]  mode,
         input logic [rpb_pkg::CHAN_WIDTH-1:0]  base_ch,
         input logic [rpb_pkg::CHAN_WIDTH-1:0]  new_ch,
         input logic [rpb_pkg::ALPHA_WIDTH-1:0] alpha_ch);
      int r;
      int b;
      int n;
      int a;
      b = int'(base_ch);
      n = int'(new_ch);
      a = int'(alpha_ch);
      case (mode)
         rpb_pkg::BLEND_MIX:      r = b + (((n - b) * a) >>> 8);   // floor of a signed scale
         rpb_pkg::BLEND_ADD:      r = b + ((n * a) >> 8);
         rpb_pkg::BLEND_SUBTRACT: r = b - ((n * a) >> 8);
         rpb_pkg::BLEND_MULTIPLY: r = (n * b) >> 8;                // alpha plays no part
         rpb_pkg::BLEND_DODGE:    r = b + ((n * b * a) >> 16);
         rpb_pkg::BLEND_INVERT:   r = b + a - ((2 * b * a) >> 8);
         default:                 r = 0;                      // black and the unused code
      endcase
      // every mode ends in a clamp to the channel range
      if (r < 0)
         r = 0;
      if (r > 255)
         r = 255;
      return r[rpb_pkg::CHAN_WIDTH-1:0];
   endfunction

   function automatic logic [rpb_pkg::COLOR_WIDTH-1:0] blend_pixel(
         input logic [rpb_pkg::MODE_WIDTH-1:0]  mode,
         input logic [rpb_pkg::COLOR_WIDTH-1:0] base_px,
         input logic [rpb_pkg::COLOR_WIDTH-1:0] over_px,
         input logic [rpb_pkg::ALPHA_WIDTH-1:0] alpha);
      logic [rpb_pkg::COLOR_WIDTH-1:0] px;
      for (int c = 0; c < rpb_pkg::NUM_CHANNELS; c++)
         px[c*rpb_pkg::CHAN_WIDTH +: rpb_pkg::CHAN_WIDTH] =
            blend_chan(mode, base_px[c*rpb_pkg::CHAN_WIDTH +: rpb_pkg::CHAN_WIDTH],
                       over_px[c*rpb_pkg::CHAN_WIDTH +: rpb_pkg::CHAN_WIDTH], alpha);
      return px;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [rpb_pkg::COLOR_WIDTH-1:0] want,
                                  input logic [rpb_pkg::COLOR_WIDTH-1:0] got);
      $display("%0t: %s: expected %06h, got %06h", $realtime, what, want, got);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // request/response monitor: predicts at request accept, checks at response
   // accept; both sides sample the values from before the edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            if (known_v)
               pending_pixels.push_back(known_px);
            else
               pending_pixels.push_back(blend_pixel(mode_shadow, req_if.base_color,
                                                    req_if.new_color, req_if.alpha));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            result_count++;
            if (pending_pixels.size() == 0) begin
               report_mismatch("response with no request pending", '0, rsp_if.blended_color);
            end else begin
               expected_px = pending_pixels.pop_front();
               if (rsp_if.blended_color !== expected_px)
                  report_mismatch($sformatf("blended_color, response %0d", result_count),
                                  expected_px, rsp_if.blended_color);
            end
         end
         // watchdog: any handshake counts as progress
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d requests, %0d responses",
                     WATCHDOG_LIMIT, sent_count, result_count);
            $display("rgb_pixel_blender: mismatch");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // response side back-pressure: stretches of a random stall density,
   // level 0 never stalls
   // ---------------------------------------------------------------------
   initial begin
      int stall_level;
      int stall_left;
      stall_level = 0;
      stall_left  = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0) begin
            stall_level = $urandom_range(0, 3);
            stall_left  = $urandom_range(16, 96);
         end
         stall_left--;
         case (stall_level)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 7) != 0);
            2:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // channel values biased toward the ends of the range, where clamps bite
   function automatic logic [rpb_pkg::CHAN_WIDTH-1:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hff;
         2:       return 8'($urandom_range(0, 3));
         3:       return 8'($urandom_range(252, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [rpb_pkg::COLOR_WIDTH-1:0] pick_color();
      return {pick_level(), pick_level(), pick_level()};
   endfunction

   // drive one request and hold it until accepted; inside a burst valid stays
   // high, at its end valid drops for a random gap
   task automatic push_pixel(input logic [rpb_pkg::COLOR_WIDTH-1:0] base_px,
                             input logic [rpb_pkg::COLOR_WIDTH-1:0] over_px,
                             input logic [rpb_pkg::ALPHA_WIDTH-1:0] alpha,
                             input bit known_flag,
                             input logic [rpb_pkg::COLOR_WIDTH-1:0] known_val);
      req_if.valid      <= 1'b1;
      req_if.base_color <= base_px;
      req_if.new_color  <= over_px;
      req_if.alpha      <= alpha;
      known_v           <= known_flag;
      known_px          <= known_val;
      do
         @(posedge clock);
      while (!req_if.ready);
      sent_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // stop sending and wait until every request has its response
   task automatic drain_pixels();
      req_if.valid <= 1'b0;
      while (result_count < sent_count)
         @(posedge clock);
   endtask

   // blend_mode write, only with the pipe empty
   task automatic set_mode(input logic [rpb_pkg::MODE_WIDTH-1:0] mode);
      drain_pixels();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      mode_shadow = mode;
      mode_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic add_case(input logic [rpb_pkg::MODE_WIDTH-1:0] mode,
                           input logic [rpb_pkg::COLOR_WIDTH-1:0] base_px,
                           input logic [rpb_pkg::COLOR_WIDTH-1:0] over_px,
                           input logic [rpb_pkg::ALPHA_WIDTH-1:0] alpha,
                           input bit known_flag,
                           input logic [rpb_pkg::COLOR_WIDTH-1:0] known_val);
      pixel_case_type row;
      row.mode     = mode;
      row.base_px  = base_px;
      row.over_px  = over_px;
      row.alpha    = alpha;
      row.known_v  = known_flag;
      row.known_px = known_val;
      corner_cases.push_back(row);
   endtask

   initial begin
      logic [rpb_pkg::MODE_WIDTH-1:0] phase_modes[NUM_PHASES];

      // mode sequence for the random part: every code, both ends, repeats
      phase_modes = '{rpb_pkg::BLEND_MIX, rpb_pkg::BLEND_ADD, rpb_pkg::BLEND_SUBTRACT,
                      rpb_pkg::BLEND_MULTIPLY, rpb_pkg::BLEND_DODGE, rpb_pkg::BLEND_INVERT,
                      rpb_pkg::BLEND_BLACK, BLEND_UNUSED, rpb_pkg::BLEND_INVERT,
                      rpb_pkg::BLEND_MIX, rpb_pkg::BLEND_DODGE, rpb_pkg::BLEND_SUBTRACT,
                      rpb_pkg::BLEND_ADD, rpb_pkg::BLEND_MULTIPLY};

      // every input known from time zero
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = rpb_pkg::BLEND_BLACK;
      req_if.valid      = 1'b0;
      req_if.base_color = '0;
      req_if.new_color  = '0;
      req_if.alpha      = '0;
      known_v           = 1'b0;
      known_px          = '0;
      mode_shadow       = rpb_pkg::BLEND_BLACK;

      // directed corners; a set known flag means the response is typed in,
      // otherwise the predictor supplies it
      // black straight out of reset, no register write yet
      add_case(rpb_pkg::BLEND_BLACK,    24'hffffff, 24'hffffff, 8'hff, 1'b1, 24'h000000);
      add_case(rpb_pkg::BLEND_BLACK,    24'h5a3cf0, 24'ha5c30f, 8'h80, 1'b1, 24'h000000);
      // the unused selector also gives black
      add_case(BLEND_UNUSED,            24'hffffff, 24'h123456, 8'h80, 1'b1, 24'h000000);
      // mix: zero alpha or equal colors keep the base; large negative
      // differences still floor into range
      add_case(rpb_pkg::BLEND_MIX,      24'ha5c30f, 24'h5a3cf0, 8'h00, 1'b1, 24'ha5c30f);
      add_case(rpb_pkg::BLEND_MIX,      24'h7f7f7f, 24'h7f7f7f, 8'hff, 1'b1, 24'h7f7f7f);
      add_case(rpb_pkg::BLEND_MIX,      24'h000000, 24'hffffff, 8'hff, 1'b0, '0);
      add_case(rpb_pkg::BLEND_MIX,      24'hffffff, 24'h000000, 8'hff, 1'b0, '0);
      add_case(rpb_pkg::BLEND_MIX,      24'hff00ff, 24'h00ff00, 8'h80, 1'b0, '0);
      // add saturates at white
      add_case(rpb_pkg::BLEND_ADD,      24'hffffff, 24'hffffff, 8'hff, 1'b1, 24'hffffff);
      add_case(rpb_pkg::BLEND_ADD,      24'h000000, 24'hffffff, 8'h00, 1'b1, 24'h000000);
      add_case(rpb_pkg::BLEND_ADD,      24'h102030, 24'hffffff, 8'hff, 1'b0, '0);
      // subtract clamps at zero
      add_case(rpb_pkg::BLEND_SUBTRACT, 24'h000000, 24'hffffff, 8'hff, 1'b1, 24'h000000);
      add_case(rpb_pkg::BLEND_SUBTRACT, 24'hffffff, 24'hffffff, 8'h00, 1'b1, 24'hffffff);
      add_case(rpb_pkg::BLEND_SUBTRACT, 24'h806040, 24'hffffff, 8'hff, 1'b0, '0);
      // multiply ignores alpha
      add_case(rpb_pkg::BLEND_MULTIPLY, 24'hffffff, 24'h000000, 8'hff, 1'b1, 24'h000000);
      add_case(rpb_pkg::BLEND_MULTIPLY, 24'hffffff, 24'hffffff, 8'h00, 1'b0, '0);
      // dodge saturates at white
      add_case(rpb_pkg::BLEND_DODGE,    24'hffffff, 24'hffffff, 8'hff, 1'b1, 24'hffffff);
      add_case(rpb_pkg::BLEND_DODGE,    24'h000000, 24'hffffff, 8'hff, 1'b1, 24'h000000);
      add_case(rpb_pkg::BLEND_DODGE,    24'h808080, 24'hffffff, 8'hff, 1'b0, '0);
      // invert reaches both ends of the channel range
      add_case(rpb_pkg::BLEND_INVERT,   24'h000000, 24'h000000, 8'h00, 1'b1, 24'h000000);
      add_case(rpb_pkg::BLEND_INVERT,   24'h000000, 24'h000000, 8'hff, 1'b1, 24'hffffff);
      add_case(rpb_pkg::BLEND_INVERT,   24'hffffff, 24'hffffff, 8'h00, 1'b1, 24'hffffff);
      add_case(rpb_pkg::BLEND_INVERT,   24'hffffff, 24'h000000, 8'hff, 1'b0, '0);
      add_case(rpb_pkg::BLEND_INVERT,   24'h010280, 24'h000000, 8'hff, 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_cases[i]) begin
         if (corner_cases[i].mode != mode_shadow)
            set_mode(corner_cases[i].mode);
         push_pixel(corner_cases[i].base_px, corner_cases[i].over_px, corner_cases[i].alpha,
                    corner_cases[i].known_v, corner_cases[i].known_px);
         directed_count++;
      end

      // random phases, one blend_mode setting each; from here on the
      // predictor supplies every expectation
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_mode(phase_modes[p]);
         for (int k = 0; k < PHASE_PIXELS; k++) begin
            // once, let the pipe run dry in the middle of a phase
            if (p == NUM_PHASES / 2 && k == PHASE_PIXELS / 2)
               drain_pixels();
            push_pixel(pick_color(), pick_color(), pick_level(), 1'b0, '0);
         end
      end

      drain_pixels();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests (%0d directed corners), %0d responses checked",
               sent_count, directed_count, result_count);
      $display("%0d blend_mode writes over all eight selector codes, %0d mismatches",
               mode_writes, error_count);
      if (error_count == 0 && pending_pixels.size() == 0)
         $display("rgb_pixel_blender: match");
      else
         $display("rgb_pixel_blender: mismatch");
      $finish;
   end

endmodule
